/* sv/assert_macros.svh */
// assertion macros used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RLRQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define RLRQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/rlrq_pkg.sv */
// types, codes and defaults of the rate limited receive queue
package rlrq_pkg;
	localparam int FIFO_DEPTH_DEF   = 16;
	localparam int BIND_ENTRIES_DEF = 16;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_RXDONE = 2'd1;
	localparam logic [1:0] OP_BIND   = 2'd2;
	localparam logic [1:0] OP_UNBIND = 2'd3;

	localparam logic [2:0] KIND_BUFFERED  = 3'd0;
	localparam logic [2:0] KIND_DROP_FULL = 3'd1;
	localparam logic [2:0] KIND_DELIVERED = 3'd2;
	localparam logic [2:0] KIND_DROP_UNB  = 3'd3;
	localparam logic [2:0] KIND_CALLBACK  = 3'd4;
	localparam logic [2:0] KIND_BIND_OK   = 3'd5;
	localparam logic [2:0] KIND_BIND_FULL = 3'd6;
	localparam logic [2:0] KIND_UNBOUND   = 3'd7;

	localparam logic [1:0] REG_CAPACITY = 2'd0;
	localparam logic [1:0] REG_NS_BYTE  = 2'd1;
	localparam logic [1:0] REG_BATCH    = 2'd2;

	localparam logic [23:0] CAPACITY_RST = 24'd65536;
	localparam logic [35:0] NS_BYTE_RST  = 36'd524288;
	localparam logic [31:0] BATCH_RST    = 32'd10000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] packet_length;
		logic [31:0] dest_key;
		logic [63:0] now_ns;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] out_key;
		logic [15:0] out_length;
		logic [47:0] delay_ns;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [23:0] buffer_capacity_bytes;
		logic [35:0] ns_per_byte_q16;
		logic [31:0] batch_time_ns;
	} cfg_t;

	typedef struct packed {
		logic latch;
		logic arrive;
		logic intv;
		logic absorb;
		logic pop;
		logic read;
		logic mul;
		logic add;
		logic srch_start;
		logic srch_from_pkt;
		logic srch_step;
		logic srch_pkt;
		logic cb;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic arrive_ok;
		logic recv;
		logic can_pop;
		logic srch_last;
	} stat_t;
endpackage

/* sv/rate_limited_receive_queue.sv */
// top level of the rate limited receive queue
//
// channel   signals                               beat taken when
// input     start, busy, in_item                  start && !busy
// result    result_valid, result                  result_valid (one cycle)
// config    psel, penable, pwrite, paddr, pwdata  psel && penable && pwrite
//
// bind and unbind scan the key table one entry a cycle, then flush. an
// arrival has its arrive step, then the flush or its drain pass; a receive
// done has an interval step and an absorb step, then its drain pass.
// a drain pass pops one packet at a time (fifo read, two step multiply,
// debt add, key scan) and ends with the last check, the callback and the
// flush. results trail by one beat and the receiver cannot stall them.
// reset is asynchronous; there is no clearing pass.
`include "assert_macros.svh"
module rate_limited_receive_queue #(
	parameter int FIFO_DEPTH   = rlrq_pkg::FIFO_DEPTH_DEF,
	parameter int BIND_ENTRIES = rlrq_pkg::BIND_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rlrq_pkg::in_item_t in_item,
	output logic               result_valid,
	output rlrq_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import rlrq_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	assign pready = 1'b1;

	rlrq_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	rlrq_ctrl u_ctrl (
		.clk, .arst_n, .start, .opcode(in_item.opcode), .stat, .cmd, .busy
	);

	rlrq_dp #(
		.FIFO_DEPTH(FIFO_DEPTH),
		.BIND_ENTRIES(BIND_ENTRIES)
	) u_dp (
		.clk, .arst_n, .cfg, .in_item, .cmd, .stat, .result, .result_valid
	);

	`RLRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`RLRQ_ASSERT_NOW(a_result_in_item, result_valid, $past(busy))
	`RLRQ_ASSERT_NOW(a_callback_delay, result_valid && result.kind == KIND_CALLBACK,
		result.delay_ns != 48'd0)
endmodule

/* sv/rlrq_regs.sv */
// configuration registers behind the apb-style port
module rlrq_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output rlrq_pkg::cfg_t   cfg
);
	import rlrq_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_capacity_bytes <= CAPACITY_RST;
			cfg_q.ns_per_byte_q16       <= NS_BYTE_RST;
			cfg_q.batch_time_ns         <= BATCH_RST;
		end else if (wr) begin
			case (paddr[4:3])
				REG_CAPACITY: cfg_q.buffer_capacity_bytes <= pwdata[23:0];
				REG_NS_BYTE:  cfg_q.ns_per_byte_q16       <= pwdata[35:0];
				REG_BATCH:    cfg_q.batch_time_ns         <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			REG_CAPACITY: prdata = {40'd0, cfg_q.buffer_capacity_bytes};
			REG_NS_BYTE:  prdata = {28'd0, cfg_q.ns_per_byte_q16};
			REG_BATCH:    prdata = {32'd0, cfg_q.batch_time_ns};
			default:      prdata = 64'd0;
		endcase
	end

	assign cfg = cfg_q;
endmodule

/* sv/rlrq_ctrl.sv */
// sequencing state machine of the receive queue
module rlrq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      opcode,
	input  rlrq_pkg::stat_t stat,
	output rlrq_pkg::cmd_t  cmd,
	output logic            busy
);
	import rlrq_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_ARRIVE = 12'b000000000010,
		S_INTV   = 12'b000000000100,
		S_ABSORB = 12'b000000001000,
		S_CHECK  = 12'b000000010000,
		S_READ   = 12'b000000100000,
		S_MUL    = 12'b000001000000,
		S_ADD    = 12'b000010000000,
		S_PSRCH  = 12'b000100000000,
		S_BSRCH  = 12'b001000000000,
		S_CB     = 12'b010000000000,
		S_FLUSH  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					case (opcode)
						OP_ARRIVE: state_d = S_ARRIVE;
						OP_RXDONE: state_d = S_INTV;
						default: begin
							cmd.srch_start = 1'b1;
							state_d = S_BSRCH;
						end
					endcase
				end
			end
			S_ARRIVE: begin
				cmd.arrive = 1'b1;
				state_d = (stat.arrive_ok && !stat.recv) ? S_CHECK : S_FLUSH;
			end
			S_INTV: begin
				cmd.intv = 1'b1;
				state_d = S_ABSORB;
			end
			S_ABSORB: begin
				cmd.absorb = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (stat.can_pop) begin
					cmd.pop = 1'b1;
					state_d = S_READ;
				end else begin
					state_d = S_CB;
				end
			end
			S_READ: begin
				cmd.read          = 1'b1;
				cmd.srch_start    = 1'b1;
				cmd.srch_from_pkt = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_PSRCH;
			end
			S_PSRCH: begin
				cmd.srch_step = 1'b1;
				cmd.srch_pkt  = 1'b1;
				if (stat.srch_last) state_d = S_CHECK;
			end
			S_BSRCH: begin
				cmd.srch_step = 1'b1;
				if (stat.srch_last) state_d = S_FLUSH;
			end
			S_CB: begin
				cmd.cb = 1'b1;
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

/* sv/rlrq_dp.sv */
// datapath: packet fifo, byte and debt accounting, key table, result staging
module rlrq_dp #(
	parameter int FIFO_DEPTH   = rlrq_pkg::FIFO_DEPTH_DEF,
	parameter int BIND_ENTRIES = rlrq_pkg::BIND_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rlrq_pkg::cfg_t     cfg,
	input  rlrq_pkg::in_item_t in_item,
	input  rlrq_pkg::cmd_t     cmd,
	output rlrq_pkg::stat_t    stat,
	output rlrq_pkg::result_t  result,
	output logic               result_valid
);
	import rlrq_pkg::*;

	localparam int FW = $clog2(FIFO_DEPTH);
	localparam int CW = FW + 1;
	localparam int IW = (BIND_ENTRIES > 1) ? $clog2(BIND_ENTRIES) : 1;

	typedef struct packed {
		logic [31:0] key;
		logic [15:0] len;
	} ent_t;

	ent_t        mem [FIFO_DEPTH];
	ent_t        rd_q;
	in_item_t    in_q;
	logic [FW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [23:0] used_q;
	logic [63:0] debt_q;
	logic [63:0] last_time_q;
	logic [63:0] intv_q;
	logic        recv_q;
	logic [33:0] plo_s1, phi_s1;
	logic [51:0] charge_q;

	logic [BIND_ENTRIES-1:0] bvalid_q;
	logic [31:0] bkey_q [BIND_ENTRIES];
	logic [31:0] skey_q;
	logic [IW-1:0] idx_q, fidx_q, fridx_q;
	logic        found_q, free_q;

	result_t     pend_q, res_q, rnew;
	logic        pend_v_q, res_v_q, emit;

	logic [23:0] space;
	logic [CW-1:0] tail_sum;
	logic [FW-1:0] tail;
	logic        match, free_here, f_any, fr_any;
	logic [IW-1:0] f_idx, fr_idx;
	logic [64:0] dsum;
	logic [63:0] dsub;

	assign space    = (cfg.buffer_capacity_bytes > used_q) ?
	                  cfg.buffer_capacity_bytes - used_q : 24'd0;
	assign tail_sum = {1'b0, head_q} + count_q;
	assign tail     = (tail_sum >= CW'(FIFO_DEPTH)) ?
	                  FW'(tail_sum - CW'(FIFO_DEPTH)) : tail_sum[FW-1:0];

	assign stat.arrive_ok = ({8'd0, in_q.packet_length} <= space) &&
	                        (count_q < CW'(FIFO_DEPTH));
	assign stat.recv      = recv_q;
	assign stat.can_pop   = (count_q != '0) &&
	                        (debt_q <= {16'd0, cfg.batch_time_ns, 16'd0});
	assign stat.srch_last = (idx_q == IW'(BIND_ENTRIES - 1));

	// one table entry examined per cycle
	assign match     = bvalid_q[idx_q] && (bkey_q[idx_q] == skey_q);
	assign free_here = !bvalid_q[idx_q];
	assign f_any     = found_q | match;
	assign f_idx     = found_q ? fidx_q : idx_q;
	assign fr_any    = free_q | free_here;
	assign fr_idx    = free_q ? fridx_q : idx_q;

	assign dsum = {1'b0, debt_q} + {13'd0, charge_q};
	assign dsub = {intv_q[47:0], 16'd0};

	// new result of this cycle
	always_comb begin
		emit = 1'b0;
		rnew = '0;
		if (cmd.arrive) begin
			emit = 1'b1;
			rnew.kind       = stat.arrive_ok ? KIND_BUFFERED : KIND_DROP_FULL;
			rnew.out_key    = in_q.dest_key;
			rnew.out_length = in_q.packet_length;
		end else if (cmd.srch_step && stat.srch_last) begin
			emit = 1'b1;
			rnew.out_key = skey_q;
			if (cmd.srch_pkt) begin
				rnew.kind       = f_any ? KIND_DELIVERED : KIND_DROP_UNB;
				rnew.out_length = rd_q.len;
			end else if (in_q.opcode == OP_BIND) begin
				rnew.kind = (f_any || fr_any) ? KIND_BIND_OK : KIND_BIND_FULL;
			end else begin
				rnew.kind = KIND_UNBOUND;
			end
		end else if (cmd.cb && (debt_q[63:16] != 48'd0)) begin
			emit = 1'b1;
			rnew.kind     = KIND_CALLBACK;
			rnew.delay_ns = debt_q[63:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) in_q <= in_item;
		if (cmd.arrive && stat.arrive_ok) begin
			mem[tail] <= '{key: in_q.dest_key, len: in_q.packet_length};
		end
		if (cmd.pop) rd_q <= mem[head_q];
		if (cmd.read) begin
			plo_s1 <= rd_q.len * cfg.ns_per_byte_q16[17:0];
			phi_s1 <= rd_q.len * cfg.ns_per_byte_q16[35:18];
		end
		if (cmd.mul) charge_q <= {18'd0, plo_s1} + {phi_s1, 18'd0};
		if (cmd.intv) intv_q <= in_q.now_ns - last_time_q;
		if (cmd.srch_start) skey_q <= cmd.srch_from_pkt ? rd_q.key : in_item.dest_key;
		if (cmd.srch_step) begin
			if (!found_q && match) fidx_q <= idx_q;
			if (!free_q && free_here) fridx_q <= idx_q;
		end
		if (cmd.srch_step && stat.srch_last && !cmd.srch_pkt &&
		    in_q.opcode == OP_BIND && !f_any && fr_any) begin
			bkey_q[fr_idx] <= skey_q;
		end
		if (emit) pend_q <= rnew;
		if (emit && pend_v_q) res_q <= '{kind: pend_q.kind, out_key: pend_q.out_key,
			out_length: pend_q.out_length, delay_ns: pend_q.delay_ns, last: 1'b0};
		else if (cmd.flush && pend_v_q) res_q <= '{kind: pend_q.kind,
			out_key: pend_q.out_key, out_length: pend_q.out_length,
			delay_ns: pend_q.delay_ns, last: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			used_q      <= '0;
			debt_q      <= '0;
			last_time_q <= '0;
			recv_q      <= 1'b0;
			bvalid_q    <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			res_v_q     <= 1'b0;
		end else begin
			if (cmd.arrive && stat.arrive_ok) begin
				count_q <= count_q + 1'b1;
				used_q  <= used_q + {8'd0, in_q.packet_length};
			end
			if (cmd.pop) begin
				head_q  <= (head_q == FW'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (cmd.read) begin
				used_q <= (used_q >= {8'd0, rd_q.len}) ? used_q - {8'd0, rd_q.len} : 24'd0;
			end
			if (cmd.add) debt_q <= dsum[64] ? {64{1'b1}} : dsum[63:0];
			if (cmd.intv) begin
				last_time_q <= in_q.now_ns;
				recv_q      <= 1'b0;
			end
			// an interval of 2^48 ns or more clears the debt
			if (cmd.absorb && intv_q != 64'd0) begin
				if (intv_q[63:48] != 16'd0) debt_q <= '0;
				else debt_q <= (debt_q > dsub) ? debt_q - dsub : 64'd0;
			end
			if (cmd.cb && (debt_q[63:16] != 48'd0)) recv_q <= 1'b1;
			if (cmd.srch_start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.srch_step) begin
				idx_q   <= idx_q + 1'b1;
				found_q <= f_any;
				free_q  <= fr_any;
			end
			if (cmd.srch_step && stat.srch_last && !cmd.srch_pkt) begin
				if (in_q.opcode == OP_BIND) begin
					if (!f_any && fr_any) bvalid_q[fr_idx] <= 1'b1;
				end else if (f_any) begin
					bvalid_q[f_idx] <= 1'b0;
				end
			end
			// one result held back so the final beat can carry last
			res_v_q <= (emit || cmd.flush) && pend_v_q;
			if (emit) pend_v_q <= 1'b1;
			else if (cmd.flush) pend_v_q <= 1'b0;
		end
	end

	assign result       = res_q;
	assign result_valid = res_v_q;
endmodule
